FILE: rtl/bdavg_pkg.sv
// Shared types and constants for the battery divider averaging block.
// Holds payload structs, register indexes, reset values and divider request types.
// No dependencies.
`timescale 1ns / 1ps

package bdavg_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int REG_W    = 16;
	localparam int MV_W     = 16;
	localparam int CFG_IDX_W = 8;

	// Default run length limit
	localparam int MAX_SAMPLES_DEF = 64;

	// Divider sizing: numerator is avg(16) * vref(16) * 2 * cal(16)
	localparam int DVD_W = 2 * REG_W + SAMPLE_W + 1;
	// Denominator is full_scale(16) * 1000 (10 bits)
	localparam int DEN_W = REG_W + 10;

	localparam logic [MV_W-1:0] MV_MAX = '1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VREF    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FS      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_DEF = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_OVR = 8'd3;

	// Register reset values
	localparam logic [REG_W-1:0] VREF_RST    = 16'd3000;
	localparam logic [REG_W-1:0] FS_RST      = 16'd4096;
	localparam logic [REG_W-1:0] CAL_DEF_RST = 16'd1000;
	localparam logic [REG_W-1:0] CAL_OVR_RST = 16'd0;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} in_t;

	typedef struct packed {
		logic [MV_W-1:0] millivolts;
		logic            too_many;
	} out_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/bdavg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bdavg_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module bdavg_div import bdavg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [DVD_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// Shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: latch operands on start, then advance one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			div_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: rtl/battery_divider_average_to_millivolts_core.sv
// Battery divider averaging core: accumulates ADC samples per run and converts
// the rounded average to millivolts. Depends on bdavg_pkg and bdavg_div.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | in        | in_valid / in_ready  | in_data  (sample, last)
//   out     | out       | out_valid / out_ready| out_data (millivolts, too_many)
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A sample with last starts the conversion, in which the shared divider runs twice,
// one bit a cycle: first for the rounded average, then for the millivolt scaling.
// in_ready stays low until the result moves to the output register; it waits there
// while the next run starts, and a second result holds in_ready low until it is taken.
// Reset is asynchronous and clears the run state and loads the register defaults.
// cfg_ready is always high.
`timescale 1ns / 1ps

module battery_divider_average_to_millivolts_core import bdavg_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;

	typedef enum logic [2:0] {
		S_ACC,
		S_AVG,
		S_AVG_WAIT,
		S_MUL1,
		S_MUL2,
		S_MV,
		S_MV_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic [REG_W-1:0] vref_q;
	logic [REG_W-1:0] fs_q;
	logic [REG_W-1:0] cal_def_q;
	logic [REG_W-1:0] cal_ovr_q;

	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q;
	logic                  overrun_q;
	logic [SAMPLE_W-1:0]   avg_q;
	logic [2*REG_W-1:0]    prod_q;
	logic [DVD_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic [MV_W-1:0]       mv_q;
	logic                  out_valid_q;
	out_t                  out_q;

	logic                  in_xfer;
	logic                  room;
	logic                  out_load;
	logic [REG_W-1:0]      cal;
	logic [SUM_W:0]        rounded;
	logic [DEN_W-1:0]      den_calc;
	logic [MV_W-1:0]       mv_sat;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign in_ready  = (state_q == S_ACC);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign room      = count_q < CNT_W'(MAX_SAMPLES);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign cal       = (cal_ovr_q != '0) ? cal_ovr_q : cal_def_q;
	assign rounded   = {1'b0, sum_q} + (SUM_W+1)'(count_q >> 1);

	// full_scale * 1000 as shifts and subtracts
	assign den_calc = (DEN_W'(fs_q) << 10) - (DEN_W'(fs_q) << 4) - (DEN_W'(fs_q) << 3);

	// Saturate the scaled quotient; a zero divisor saturates as well
	assign mv_sat = ((den_q == '0) || (div_rsp.quotient[DVD_W-1:MV_W] != '0))
		? MV_MAX : div_rsp.quotient[MV_W-1:0];

	// Drive the shared divider
	always_comb begin
		div_req.start    = (state_q == S_AVG) || (state_q == S_MV);
		div_req.dividend = (state_q == S_MV) ? num_q : DVD_W'(rounded);
		div_req.divisor  = (state_q == S_MV) ? den_q : DEN_W'(count_q);
	end

	bdavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q    <= VREF_RST;
			fs_q      <= FS_RST;
			cal_def_q <= CAL_DEF_RST;
			cal_ovr_q <= CAL_OVR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VREF:    vref_q    <= cfg_data;
				REG_FS:      fs_q      <= cfg_data;
				REG_CAL_DEF: cal_def_q <= cfg_data;
				REG_CAL_OVR: cal_ovr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, run state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			sum_q       <= '0;
			count_q     <= '0;
			overrun_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ACC: begin
					if (in_xfer) begin
						if (room) begin
							sum_q   <= sum_q + SUM_W'(in_data.sample);
							count_q <= count_q + 1'b1;
						end else begin
							overrun_q <= 1'b1;
						end
						if (in_data.last) begin
							state_q <= S_AVG;
						end
					end
				end
				S_AVG:      state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:     state_q <= S_MUL2;
				S_MUL2:     state_q <= S_MV;
				S_MV:       state_q <= S_MV_WAIT;
				S_MV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the output register is free, then clear the run
					if (out_load) begin
						sum_q     <= '0;
						count_q   <= '0;
						overrun_q <= 1'b0;
						state_q   <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_AVG_WAIT && div_rsp.done) begin
			avg_q <= (div_rsp.quotient[DVD_W-1:SAMPLE_W] != '0)
				? '1 : div_rsp.quotient[SAMPLE_W-1:0];
		end
		if (state_q == S_MUL1) begin
			prod_q <= avg_q * vref_q;
		end
		if (state_q == S_MUL2) begin
			num_q <= {(DVD_W-1)'(prod_q) * (DVD_W-1)'(cal), 1'b0};
			den_q <= den_calc;
		end
		if (state_q == S_MV_WAIT && div_rsp.done) begin
			mv_q <= mv_sat;
		end
		if (out_load) begin
			out_q.millivolts <= mv_q;
			out_q.too_many   <= overrun_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Run counter never passes the limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count exceeds limit");

	// A run-ending transfer stops intake on the next cycle
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_data.last |=> !in_ready)
		else $error("input still ready after last sample");

	// Divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_AVG_WAIT || state_q == S_MV_WAIT))
		else $error("divider done outside a wait state");

	// A new result is loaded only into a free or draining output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid_q) && !$past(out_ready) |-> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for battery_divider_average_to_millivolts_core.
// Predicts each run's rounded average and millivolt scaling and compares every
// output transfer in order. Depends on bdavg_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import bdavg_pkg::*;

	localparam int  CLK_HALF_NS  = 6;
	localparam int  RUN_MAX      = MAX_SAMPLES_DEF;
	localparam int  SETTLE_CYC   = 2 * DVD_W + 20;
	localparam int  HOLD_CYC     = 400;
	localparam time TIMEOUT_NS   = 5_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	// Traffic shaping knobs; idle and stall rates in percent, and an output hold flag
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_out       = 1'b0;

	// Predictor copy of the registers and the run state
	logic [REG_W-1:0] cfg_vref    = VREF_RST;
	logic [REG_W-1:0] cfg_fs      = FS_RST;
	logic [REG_W-1:0] cfg_cal_def = CAL_DEF_RST;
	logic [REG_W-1:0] cfg_cal_ovr = CAL_OVR_RST;
	logic [21:0]      run_sum     = '0;
	logic [6:0]       run_count   = '0;
	logic             run_overrun = 1'b0;

	out_t mv_expect_q[$];
	out_t mv_want;
	int   err_count = 0;

	battery_divider_average_to_millivolts_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF_NS clk = ~clk;

	// Fold one accepted sample into the run; on last, queue the expected reading
	function automatic void accumulate_sample(in_t item);
		logic [63:0]     avg;
		logic [63:0]     cal;
		logic [63:0]     num;
		logic [63:0]     den;
		logic [63:0]     quot;
		logic [MV_W-1:0] mv;
		if (run_count < RUN_MAX) begin
			run_sum   = run_sum + item.sample;
			run_count = run_count + 7'd1;
		end else begin
			run_overrun = 1'b1;
		end
		if (!item.last)
			return;
		avg = (64'(run_sum) + 64'(run_count) / 2) / 64'(run_count);
		if (avg > 64'hFFFF)
			avg = 64'hFFFF;
		cal = (cfg_cal_ovr != 0) ? 64'(cfg_cal_ovr) : 64'(cfg_cal_def);
		num = avg * 64'(cfg_vref) * 64'd2 * cal;
		den = 64'(cfg_fs) * 64'd1000;
		if (den == 0) begin
			mv = MV_MAX;
		end else begin
			quot = num / den;
			mv   = (quot > 64'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];
		end
		mv_expect_q.push_back(out_t'{millivolts: mv, too_many: run_overrun});
		run_sum     = '0;
		run_count   = '0;
		run_overrun = 1'b0;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Bias register values toward their extremes and toward 1000 to 5000
	function automatic logic [REG_W-1:0] random_reg(input int lo);
		case ($urandom_range(0, 7))
			0: return REG_W'(lo);
			1: return '1;
			2, 3: return REG_W'($urandom_range(1000, 5000));
			default: return REG_W'($urandom_range(lo, 65535));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	// Offer one sample, wait for the transfer, then predict
	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
		in_t item;
		item.sample = value;
		item.last   = is_last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		accumulate_sample(item);
	endtask

	// Write all four registers in index order; the block must be idle
	task automatic set_config(input logic [REG_W-1:0] vref, input logic [REG_W-1:0] fs,
			input logic [REG_W-1:0] cal_def, input logic [REG_W-1:0] cal_ovr);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [REG_W-1:0]     vals[4];
		idx  = '{REG_VREF, REG_FS, REG_CAL_DEF, REG_CAL_OVR};
		vals = '{vref, fs, cal_def, cal_ovr};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_VREF:    cfg_vref    = vals[i];
				REG_FS:      cfg_fs      = vals[i];
				REG_CAL_DEF: cfg_cal_def = vals[i];
				REG_CAL_OVR: cfg_cal_ovr = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic set_random_config();
		set_config(random_reg(1), random_reg(1), random_reg(1),
			($urandom_range(0, 1) == 0) ? '0 : random_reg(1));
	endtask

	// Drop valid, wait for every expected reading, then let the divider settle
	task automatic drain();
		in_valid <= 1'b0;
		while (mv_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Mostly short runs, some up to the sample limit, a few past it
	task automatic send_random_runs(input int n_items);
		int sent;
		int pick;
		int run_len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				run_len = $urandom_range(1, 4);
			else if (pick < 85)
				run_len = $urandom_range(5, 20);
			else if (pick < 96)
				run_len = $urandom_range(21, RUN_MAX);
			else
				run_len = $urandom_range(RUN_MAX + 1, RUN_MAX + 8);
			for (int k = 1; k <= run_len; k++)
				send_sample(random_sample(), k == run_len);
			sent += (run_len > RUN_MAX) ? RUN_MAX : run_len;
		end
	endtask

	task automatic hold_output(input int cycles);
		hold_out <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_out <= 1'b0;
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// Single-sample runs at both ends of the range
		send_sample('0, 1'b1);
		send_sample('1, 1'b1);
		// Rounding of the average
		send_sample(16'd1, 1'b0);
		send_sample(16'd2, 1'b1);
		send_sample('1, 1'b0);
		send_sample('1, 1'b1);
		send_sample(16'd100, 1'b0);
		send_sample(16'd101, 1'b0);
		send_sample(16'd102, 1'b1);
		drain();
		// Zero full scale saturates
		set_config(VREF_RST, '0, CAL_DEF_RST, '0);
		send_sample(16'd1000, 1'b1);
		drain();
		// Zero calibration gives zero
		set_config(VREF_RST, FS_RST, '0, '0);
		send_sample(16'd4000, 1'b1);
		drain();
		// Override takes precedence over the default
		set_config(VREF_RST, FS_RST, CAL_DEF_RST, 16'd500);
		send_sample(16'd4000, 1'b1);
		drain();
		// Largest gain saturates even for a reading of one; a zero reading gives zero
		set_config('1, 16'd1, '1, '1);
		send_sample(16'd1, 1'b1);
		send_sample('0, 1'b1);
		drain();
		// Smallest gain truncates to zero
		set_config(16'd1, '1, 16'd1, '0);
		send_sample('1, 1'b1);
		drain();
	endtask

	task automatic test_run_limit();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(VREF_RST, FS_RST, CAL_DEF_RST, CAL_OVR_RST);
		// Exactly full: no overrun
		for (int k = 1; k <= RUN_MAX; k++)
			send_sample(random_sample(), k == RUN_MAX);
		// Last arrives one past full
		for (int k = 1; k <= RUN_MAX + 1; k++)
			send_sample('1, k == RUN_MAX + 1);
		// Several extras ignored
		for (int k = 1; k <= RUN_MAX + 6; k++)
			send_sample(random_sample(), k == RUN_MAX + 6);
		drain();
	endtask

	task automatic test_no_idling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(VREF_RST, FS_RST, CAL_DEF_RST, CAL_OVR_RST);
		send_random_runs(130);
		drain();
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 72;
		recv_stall_pct = 0;
		set_random_config();
		send_random_runs(130);
		drain();
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 72;
		set_random_config();
		send_random_runs(130);
		drain();
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		set_random_config();
		send_random_runs(130);
		drain();
	endtask

	// Stall the output long enough that the input backs up
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_random_config();
		fork
			hold_output(HOLD_CYC);
		join_none
		for (int r = 0; r < 3; r++)
			for (int k = 1; k <= 6; k++)
				send_sample(random_sample(), k == 6);
		send_random_runs(80);
		drain();
	endtask

	// Receiver: random stalls, forced low during a hold
	always @(posedge clk) begin
		if (hold_out)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare every output transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (mv_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result mv=%0d too_many=%0b",
					out_data.millivolts, out_data.too_many));
			end else begin
				mv_want = mv_expect_q.pop_front();
				if (out_data.millivolts !== mv_want.millivolts)
					report_mismatch($sformatf("millivolts got %0d want %0d",
						out_data.millivolts, mv_want.millivolts));
				if (out_data.too_many !== mv_want.too_many)
					report_mismatch($sformatf("too_many got %0b want %0b",
						out_data.too_many, mv_want.too_many));
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_run_limit();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		if (err_count == 0 && mv_expect_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#TIMEOUT_NS;
		$display("TIMEOUT at %0t ns", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
